// File: hw/rtl/assert_macros.svh
// Assertion macros for the envelope gain RTL.
// Included by files that carry concurrent assertions; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, sampled on the rising edge, ignored in reset.
`define EEG_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be seen on a rising edge outside reset.
`define EEG_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// File: hw/rtl/eeg_pkg.sv
// Types, codes and constant tables for the exponential envelope gain block.
// Used by every module of the block but eeg_div; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package eeg_pkg;

	localparam int FADE_FLOOR = 32;
	localparam int MAX_BLOCK = 256;
	localparam int POW_TABLE_DEPTH = 256;
	localparam int POW_IDX_W = $clog2(POW_TABLE_DEPTH + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] ACT_SAMPLE = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_END = 2'd2;

	localparam logic [1:0] MODE_LOOP = 2'd0;
	localparam logic [1:0] MODE_FADE = 2'd1;
	localparam logic [1:0] MODE_HOLD = 2'd2;

	localparam logic [2:0] REG_PHASE_STEP = 3'd0;
	localparam logic [2:0] REG_DUTY_POINT = 3'd1;
	localparam logic [2:0] REG_FLOOR_GAIN = 3'd2;
	localparam logic [2:0] REG_RISE_SHAPE = 3'd3;
	localparam logic [2:0] REG_FALL_SHAPE = 3'd4;
	localparam logic [2:0] REG_FADE_RATIO = 3'd5;
	localparam logic [2:0] REG_RUN_MODE = 3'd6;
	localparam logic [2:0] REG_BLOCK_LENGTH = 3'd7;

	typedef enum logic [1:0] {
		KIND_SAMPLE,
		KIND_START,
		KIND_END,
		KIND_NONE
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic signed [15:0] sample;
	} eeg_item_t;

	typedef enum logic [1:0] {
		RUN_SILENT,
		RUN_LOOP,
		RUN_FADE,
		RUN_HOLD
	} run_t;

	typedef enum logic {
		TAB_LOG,
		TAB_EXP
	} tab_sel_t;

	typedef enum logic [4:0] {
		BS_IDLE,
		BS_DISPATCH,
		BS_BLOCK,
		BS_LOOP_MUL,
		BS_LOOP_END,
		BS_POS,
		BS_XDIV,
		BS_NORM,
		BS_IP_RD,
		BS_IP_MUL,
		BS_A_MUL,
		BS_POW_SEL,
		BS_EXP_SH,
		BS_GAIN_NUM,
		BS_GDIV_GO,
		BS_GDIV,
		BS_COMMIT,
		BS_FADE,
		BS_SAMPLE,
		BS_SCALE_DIV,
		BS_MIX_A,
		BS_MIX_B,
		BS_APPLY,
		BS_OUT
	} back_state_t;

	typedef struct packed {
		logic [31:0] phase_step;
		logic [16:0] duty_point;
		logic [14:0] floor_gain;
		logic [15:0] rise_shape;
		logic [15:0] fall_shape;
		logic [16:0] fade_ratio;
		logic [1:0] run_mode;
		logic [8:0] block_length;
	} eeg_cfg_t;

	typedef struct packed {
		logic idle;
		logic out_wait;
	} eeg_stat_t;

	typedef logic [17:0] tab_word_t;
	typedef tab_word_t tab_t [0:POW_TABLE_DEPTH];
	typedef logic [31:0] root_t [0:16];

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bit_w;
		v = v_in;
		res = 64'd0;
		bit_w = 64'h4000_0000_0000_0000;
		while (bit_w > v)
			bit_w = bit_w >> 2;
		while (bit_w != 64'd0) begin
			if (v >= res + bit_w) begin
				v = v - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	function automatic root_t build_roots();
		root_t r;
		logic [63:0] s;
		r[0] = 32'd0;
		s = isqrt64(64'd2 << 60);
		r[1] = s[31:0];
		for (int i = 2; i <= 16; i++) begin
			s = isqrt64({32'd0, r[i - 1]} << 30);
			r[i] = s[31:0];
		end
		return r;
	endfunction

	function automatic tab_t build_exp_tab();
		tab_t t;
		root_t r;
		logic [63:0] f;
		logic [63:0] acc;
		r = build_roots();
		for (int k = 0; k <= POW_TABLE_DEPTH; k++) begin
			f = (64'(k) << 16) / POW_TABLE_DEPTH;
			if (f >= 64'd65536) begin
				t[k] = 18'd131072;
			end else begin
				acc = 64'd1 << 30;
				for (int i = 1; i <= 16; i++)
					if (f[16 - i])
						acc = (acc * {32'd0, r[i]}) >> 30;
				acc = (acc + 64'd8192) >> 14;
				t[k] = acc[17:0];
			end
		end
		return t;
	endfunction

	function automatic tab_t build_log_tab();
		tab_t t;
		logic [63:0] v;
		logic [17:0] res;
		for (int k = 0; k <= POW_TABLE_DEPTH; k++) begin
			v = (64'd1 << 30) + ((64'(k) << 30) / POW_TABLE_DEPTH);
			res = 18'd0;
			if (v >= (64'd1 << 31)) begin
				res = 18'd65536;
			end else begin
				for (int i = 0; i < 16; i++) begin
					v = (v * v) >> 30;
					res = res << 1;
					if (v >= (64'd1 << 31)) begin
						res = res | 18'd1;
						v = v >> 1;
					end
				end
			end
			t[k] = res;
		end
		return t;
	endfunction

	localparam tab_t EXP_TAB = build_exp_tab();
	localparam tab_t LOG_TAB = build_log_tab();

endpackage

`default_nettype wire

// File: hw/rtl/eeg_queue.sv
// Short queue of classified items between the front and back parts.
// Depends on eeg_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none

module eeg_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input eeg_pkg::eeg_item_t push_data,
	output logic full,
	input wire logic pop,
	output eeg_pkg::eeg_item_t pop_data,
	output logic not_empty
);

	eeg_pkg::eeg_item_t entry_q [eeg_pkg::QUEUE_DEPTH];
	logic [eeg_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [eeg_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [eeg_pkg::QUEUE_CNT_W-1:0] count_q;

	assign full = count_q == eeg_pkg::QUEUE_CNT_W'(eeg_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

// File: hw/rtl/eeg_front.sv
// Front part: takes input requests and classifies them by action.
// Depends on eeg_pkg for the action codes and item type.
`timescale 1ns / 1ps
`default_nettype none

module eeg_front (
	input wire logic item_valid,
	output logic item_stall,
	input wire logic [1:0] action,
	input wire logic signed [15:0] sample_in,
	input wire logic queue_full,
	output logic push,
	output eeg_pkg::eeg_item_t push_data
);

	assign item_stall = queue_full;
	assign push = item_valid && !queue_full;

	always_comb begin
		push_data.sample = sample_in;
		unique case (action)
			eeg_pkg::ACT_SAMPLE: push_data.kind = eeg_pkg::KIND_SAMPLE;
			eeg_pkg::ACT_START: push_data.kind = eeg_pkg::KIND_START;
			eeg_pkg::ACT_END: push_data.kind = eeg_pkg::KIND_END;
			default: push_data.kind = eeg_pkg::KIND_NONE;
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/eeg_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Stand-alone; used by the back part for block position, curve and gain ratios.
`timescale 1ns / 1ps
`default_nettype none

module eeg_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [31:0] dividend,
	input wire logic [16:0] divisor,
	output logic done,
	output logic [31:0] quotient
);

	logic busy_q;
	logic done_q;
	logic [4:0] count_q;
	logic [16:0] rem_q;
	logic [16:0] div_q;
	logic [31:0] quo_q;
	logic [17:0] shifted;
	logic fits;

	assign shifted = {rem_q, quo_q[31]};
	assign fits = shifted >= {1'b0, div_q};
	assign done = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= busy_q && (count_q == 5'd31);
			if (start) begin
				busy_q <= 1'b1;
				count_q <= '0;
			end else if (busy_q) begin
				count_q <= count_q + 5'd1;
				if (count_q == 5'd31)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? 17'(shifted - {1'b0, div_q}) : shifted[16:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/eeg_back.sv
// Back part: block-start envelope evaluation, per-sample gain and result register.
// Depends on eeg_pkg and instantiates eeg_div.
`timescale 1ns / 1ps
`default_nettype none

module eeg_back (
	input wire logic clk,
	input wire logic arst_n,
	input eeg_pkg::eeg_cfg_t cfg,
	input wire logic q_not_empty,
	input eeg_pkg::eeg_item_t q_data,
	output logic pop,
	output logic result_valid,
	input wire logic result_stall,
	output logic signed [15:0] sample_out,
	output logic active,
	output eeg_pkg::eeg_stat_t stat
);

	eeg_pkg::back_state_t state_q;
	eeg_pkg::back_state_t state_d;

	eeg_pkg::run_t run_state_q;
	eeg_pkg::run_t block_state_q;
	eeg_pkg::run_t new_run;
	logic restart_q;
	logic [31:0] phase_q;
	logic [14:0] gain_next_q;
	logic [14:0] gain_start_q;
	logic [14:0] gain_end_q;
	logic [7:0] block_index_q;

	eeg_pkg::eeg_item_t item_q;
	logic [8:0] len_q;
	logic [31:0] upper_q;
	logic rising_q;
	logic [15:0] c_q;
	logic [16:0] x_q;
	logic [16:0] m_q;
	logic [4:0] e_q;
	logic [15:0] f_q;
	eeg_pkg::tab_sel_t tab_sel_q;
	logic [17:0] tab_a_q;
	logic [17:0] tab_b_q;
	logic [15:0] ip_r_q;
	logic [17:0] ip_res_q;
	logic [5:0] q_q;
	logic [15:0] r_q;
	logic [16:0] p_q;
	logic [16:0] num_q;
	logic [14:0] endg_q;
	logic [15:0] scale_q;
	logic [31:0] mix_q;
	logic [14:0] gain_q;
	logic signed [15:0] out_sample_q;
	logic out_active_q;

	logic res_valid_q;
	logic signed [15:0] res_sample_q;
	logic res_active_q;
	logic res_free;
	logic res_load;

	logic div_start;
	logic [31:0] div_dividend;
	logic [16:0] div_divisor;
	logic div_done;
	logic [31:0] div_quo;

	logic [8:0] len_w;
	logic [7:0] idx_w;
	logic [7:0] idx_next;
	logic [16:0] d_w;
	logic [15:0] rise_w;
	logic [15:0] fall_w;
	logic [16:0] fr_w;
	logic [15:0] pos_w;
	logic rising_w;
	logic wrap_ok;
	logic [31:0] t_w;
	logic [eeg_pkg::POW_IDX_W-1:0] k_w;
	logic [eeg_pkg::POW_IDX_W-1:0] k1_w;
	logic ip_ge;
	logic [17:0] ip_diff;
	logic [33:0] ip_prod;
	logic [20:0] a_w;
	logic [37:0] a_prod;
	logic [32:0] g_sum;
	logic [31:0] fade_prod;
	logic [14:0] fade_w;
	logic [31:0] mix_sum;
	logic signed [31:0] apply_prod;

	eeg_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.done(div_done),
		.quotient(div_quo)
	);

	always_comb begin
		if (cfg.block_length == 9'd0)
			len_w = 9'd1;
		else if (cfg.block_length > 9'(eeg_pkg::MAX_BLOCK))
			len_w = 9'(eeg_pkg::MAX_BLOCK);
		else
			len_w = cfg.block_length;
		d_w = (cfg.duty_point > 17'h10000) ? 17'h10000 : cfg.duty_point;
		if (cfg.rise_shape == 16'd0)
			rise_w = 16'd1;
		else if (cfg.rise_shape > 16'd64880)
			rise_w = 16'd64880;
		else
			rise_w = cfg.rise_shape;
		if (cfg.fall_shape < 16'd7)
			fall_w = 16'd7;
		else if (cfg.fall_shape > 16'd64880)
			fall_w = 16'd64880;
		else
			fall_w = cfg.fall_shape;
		if (cfg.fade_ratio < 17'd66)
			fr_w = 17'd66;
		else if (cfg.fade_ratio > 17'h10000)
			fr_w = 17'h10000;
		else
			fr_w = cfg.fade_ratio;
	end

	assign idx_w = ({1'b0, block_index_q} >= len_w) ? 8'd0 : block_index_q;
	assign idx_next = ({1'b0, block_index_q} + 9'd1 >= len_q) ? 8'd0 : block_index_q + 8'd1;
	assign pos_w = upper_q[31:16];
	assign rising_w = {1'b0, pos_w} <= d_w;
	assign wrap_ok = (phase_q < upper_q) || (cfg.run_mode == eeg_pkg::MODE_LOOP);

	assign t_w = {16'd0, f_q} * 32'(eeg_pkg::POW_TABLE_DEPTH);
	assign k_w = eeg_pkg::POW_IDX_W'(t_w >> 16);
	assign k1_w = k_w + 1'b1;

	assign ip_ge = tab_b_q >= tab_a_q;
	assign ip_diff = ip_ge ? tab_b_q - tab_a_q : tab_a_q - tab_b_q;
	assign ip_prod = ip_diff * ip_r_q;

	assign a_w = {e_q, 16'd0} - {4'd0, ip_res_q[16:0]};
	assign a_prod = {21'd0, x_q} * {17'd0, a_w};

	assign g_sum = {18'd0, cfg.floor_gain} + {1'b0, div_quo};
	assign fade_prod = {17'd0, gain_next_q} * {15'd0, 17'h10000 - fr_w};
	assign fade_w = fade_prod[30:16];
	assign mix_sum = mix_q + {17'd0, gain_end_q} * {16'd0, scale_q};
	assign apply_prod = item_q.sample * $signed({1'b0, gain_q});

	always_comb begin
		unique case (item_q.kind)
			eeg_pkg::KIND_START: new_run = eeg_pkg::RUN_LOOP;
			eeg_pkg::KIND_END: new_run = eeg_pkg::RUN_FADE;
			default: new_run = run_state_q;
		endcase
	end

	assign res_free = !res_valid_q || !result_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			eeg_pkg::BS_IDLE:
				if (q_not_empty)
					state_d = eeg_pkg::BS_DISPATCH;
			eeg_pkg::BS_DISPATCH:
				if (item_q.kind != eeg_pkg::KIND_SAMPLE)
					state_d = eeg_pkg::BS_OUT;
				else if (idx_w == 8'd0)
					state_d = eeg_pkg::BS_BLOCK;
				else
					state_d = eeg_pkg::BS_SAMPLE;
			eeg_pkg::BS_BLOCK:
				case (run_state_q)
					eeg_pkg::RUN_LOOP: state_d = eeg_pkg::BS_LOOP_MUL;
					eeg_pkg::RUN_FADE: state_d = eeg_pkg::BS_FADE;
					default: state_d = eeg_pkg::BS_SAMPLE;
				endcase
			eeg_pkg::BS_LOOP_MUL: state_d = eeg_pkg::BS_LOOP_END;
			eeg_pkg::BS_LOOP_END:
				state_d = wrap_ok ? eeg_pkg::BS_POS : eeg_pkg::BS_COMMIT;
			eeg_pkg::BS_POS:
				state_d = (pos_w == 16'd0) ? eeg_pkg::BS_COMMIT : eeg_pkg::BS_XDIV;
			eeg_pkg::BS_XDIV:
				if (div_done)
					state_d = eeg_pkg::BS_NORM;
			eeg_pkg::BS_NORM:
				if (m_q[16])
					state_d = eeg_pkg::BS_IP_RD;
			eeg_pkg::BS_IP_RD: state_d = eeg_pkg::BS_IP_MUL;
			eeg_pkg::BS_IP_MUL:
				state_d = (tab_sel_q == eeg_pkg::TAB_LOG) ? eeg_pkg::BS_A_MUL
					: eeg_pkg::BS_EXP_SH;
			eeg_pkg::BS_A_MUL: state_d = eeg_pkg::BS_POW_SEL;
			eeg_pkg::BS_POW_SEL:
				if (r_q == 16'd0 || q_q >= 6'd31)
					state_d = eeg_pkg::BS_GAIN_NUM;
				else
					state_d = eeg_pkg::BS_IP_RD;
			eeg_pkg::BS_EXP_SH: state_d = eeg_pkg::BS_GAIN_NUM;
			eeg_pkg::BS_GAIN_NUM: state_d = eeg_pkg::BS_GDIV_GO;
			eeg_pkg::BS_GDIV_GO: state_d = eeg_pkg::BS_GDIV;
			eeg_pkg::BS_GDIV:
				if (div_done)
					state_d = eeg_pkg::BS_COMMIT;
			eeg_pkg::BS_COMMIT: state_d = eeg_pkg::BS_SAMPLE;
			eeg_pkg::BS_FADE: state_d = eeg_pkg::BS_SAMPLE;
			eeg_pkg::BS_SAMPLE:
				case (block_state_q)
					eeg_pkg::RUN_SILENT: state_d = eeg_pkg::BS_OUT;
					eeg_pkg::RUN_HOLD: state_d = eeg_pkg::BS_APPLY;
					default: state_d = eeg_pkg::BS_SCALE_DIV;
				endcase
			eeg_pkg::BS_SCALE_DIV:
				if (div_done)
					state_d = eeg_pkg::BS_MIX_A;
			eeg_pkg::BS_MIX_A: state_d = eeg_pkg::BS_MIX_B;
			eeg_pkg::BS_MIX_B: state_d = eeg_pkg::BS_APPLY;
			eeg_pkg::BS_APPLY: state_d = eeg_pkg::BS_OUT;
			eeg_pkg::BS_OUT:
				if (res_free)
					state_d = eeg_pkg::BS_IDLE;
			default: state_d = eeg_pkg::BS_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		res_load = 1'b0;
		div_start = 1'b0;
		div_dividend = '0;
		div_divisor = 17'd1;
		unique case (state_q)
			eeg_pkg::BS_IDLE: pop = q_not_empty;
			eeg_pkg::BS_POS:
				if (pos_w != 16'd0) begin
					div_start = 1'b1;
					if (rising_w) begin
						div_dividend = {pos_w, 16'd0};
						div_divisor = d_w;
					end else begin
						div_dividend = {16'(pos_w - d_w[15:0]), 16'd0};
						div_divisor = 17'h10000 - d_w;
					end
				end
			eeg_pkg::BS_GDIV_GO: begin
				div_start = 1'b1;
				div_dividend = 32'({15'd0, num_q} * {17'd0, 15'h7FFF - cfg.floor_gain});
				div_divisor = 17'h10000 - {1'b0, c_q};
			end
			eeg_pkg::BS_SAMPLE:
				if (block_state_q != eeg_pkg::RUN_SILENT && block_state_q != eeg_pkg::RUN_HOLD) begin
					div_start = 1'b1;
					div_dividend = {24'd0, block_index_q} * 32'd65535;
					div_divisor = {8'd0, len_q};
				end
			eeg_pkg::BS_OUT: res_load = res_free;
			default: ;
		endcase
	end

	assign stat.idle = state_q == eeg_pkg::BS_IDLE;
	assign stat.out_wait = (state_q == eeg_pkg::BS_OUT) && !res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eeg_pkg::BS_IDLE;
			run_state_q <= eeg_pkg::RUN_SILENT;
			block_state_q <= eeg_pkg::RUN_SILENT;
			restart_q <= 1'b0;
			phase_q <= '0;
			gain_next_q <= '0;
			gain_start_q <= '0;
			gain_end_q <= '0;
			block_index_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;
			unique case (state_q)
				eeg_pkg::BS_DISPATCH:
					if (item_q.kind == eeg_pkg::KIND_SAMPLE) begin
						block_index_q <= idx_w;
					end else if (item_q.kind != eeg_pkg::KIND_NONE) begin
						run_state_q <= new_run;
						restart_q <= 1'b1;
					end
				eeg_pkg::BS_BLOCK: begin
					block_state_q <= run_state_q;
					if (run_state_q == eeg_pkg::RUN_LOOP && restart_q) begin
						phase_q <= '0;
						restart_q <= 1'b0;
					end
					if (run_state_q == eeg_pkg::RUN_HOLD) begin
						gain_start_q <= gain_next_q;
						gain_end_q <= gain_next_q;
					end
				end
				eeg_pkg::BS_LOOP_END:
					if (!wrap_ok) begin
						if (cfg.run_mode == eeg_pkg::MODE_HOLD) begin
							run_state_q <= eeg_pkg::RUN_HOLD;
							restart_q <= 1'b1;
						end else if (cfg.run_mode == eeg_pkg::MODE_FADE) begin
							run_state_q <= eeg_pkg::RUN_FADE;
							restart_q <= 1'b1;
						end
					end
				eeg_pkg::BS_COMMIT: begin
					gain_start_q <= gain_next_q;
					gain_end_q <= endg_q;
					gain_next_q <= endg_q;
					phase_q <= upper_q;
				end
				eeg_pkg::BS_FADE: begin
					gain_start_q <= gain_next_q;
					gain_end_q <= fade_w;
					if (fade_w > 15'(eeg_pkg::FADE_FLOOR)) begin
						gain_next_q <= fade_w;
					end else begin
						gain_next_q <= '0;
						run_state_q <= eeg_pkg::RUN_SILENT;
						restart_q <= 1'b1;
					end
				end
				eeg_pkg::BS_SAMPLE: block_index_q <= idx_next;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_sample_q <= out_sample_q;
			res_active_q <= out_active_q;
		end
		unique case (state_q)
			eeg_pkg::BS_IDLE:
				if (q_not_empty)
					item_q <= q_data;
			eeg_pkg::BS_DISPATCH: begin
				len_q <= len_w;
				out_sample_q <= '0;
				out_active_q <= new_run != eeg_pkg::RUN_SILENT;
			end
			eeg_pkg::BS_LOOP_MUL:
				upper_q <= phase_q + 32'(cfg.phase_step * {23'd0, len_q});
			eeg_pkg::BS_LOOP_END:
				endg_q <= cfg.floor_gain;
			eeg_pkg::BS_POS: begin
				rising_q <= rising_w;
				c_q <= rising_w ? rise_w : fall_w;
				endg_q <= cfg.floor_gain;
			end
			eeg_pkg::BS_XDIV: begin
				x_q <= div_quo[16:0];
				m_q <= {1'b0, c_q};
				e_q <= '0;
			end
			eeg_pkg::BS_NORM:
				if (!m_q[16]) begin
					m_q <= {m_q[15:0], 1'b0};
					e_q <= e_q + 5'd1;
				end else begin
					f_q <= m_q[15:0];
					tab_sel_q <= eeg_pkg::TAB_LOG;
				end
			eeg_pkg::BS_IP_RD: begin
				if (tab_sel_q == eeg_pkg::TAB_LOG) begin
					tab_a_q <= eeg_pkg::LOG_TAB[k_w];
					tab_b_q <= eeg_pkg::LOG_TAB[k1_w];
				end else begin
					tab_a_q <= eeg_pkg::EXP_TAB[k_w];
					tab_b_q <= eeg_pkg::EXP_TAB[k1_w];
				end
				ip_r_q <= t_w[15:0];
			end
			eeg_pkg::BS_IP_MUL:
				ip_res_q <= ip_ge ? tab_a_q + ip_prod[33:16] : tab_a_q - ip_prod[33:16];
			eeg_pkg::BS_A_MUL: begin
				q_q <= a_prod[37:32] ;
				r_q <= a_prod[31:16];
			end
			eeg_pkg::BS_POW_SEL:
				if (r_q == 16'd0) begin
					p_q <= (q_q > 6'd16) ? 17'd0 : 17'h10000 >> q_q;
				end else if (q_q >= 6'd31) begin
					p_q <= '0;
				end else begin
					f_q <= 16'(17'h10000 - {1'b0, r_q});
					tab_sel_q <= eeg_pkg::TAB_EXP;
				end
			eeg_pkg::BS_EXP_SH:
				p_q <= 17'(ip_res_q >> ({1'b0, q_q} + 7'd1));
			eeg_pkg::BS_GAIN_NUM:
				if (rising_q)
					num_q <= (p_q <= 17'h10000) ? 17'h10000 - p_q : 17'd0;
				else
					num_q <= (p_q > {1'b0, c_q}) ? p_q - {1'b0, c_q} : 17'd0;
			eeg_pkg::BS_GDIV:
				if (div_done)
					endg_q <= (g_sum > 33'd32767) ? 15'h7FFF : g_sum[14:0];
			eeg_pkg::BS_SAMPLE:
				if (block_state_q == eeg_pkg::RUN_SILENT) begin
					out_sample_q <= item_q.sample;
					out_active_q <= 1'b0;
				end else if (block_state_q == eeg_pkg::RUN_HOLD) begin
					gain_q <= gain_start_q;
				end
			eeg_pkg::BS_SCALE_DIV:
				if (div_done)
					scale_q <= div_quo[15:0];
			eeg_pkg::BS_MIX_A:
				mix_q <= {17'd0, gain_start_q} * {15'd0, 17'h10000 - {1'b0, scale_q}};
			eeg_pkg::BS_MIX_B:
				gain_q <= mix_sum[30:16];
			eeg_pkg::BS_APPLY: begin
				out_sample_q <= apply_prod[30:15];
				out_active_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign result_valid = res_valid_q;
	assign sample_out = res_sample_q;
	assign active = res_active_q;

endmodule

`default_nettype wire

// File: hw/rtl/exponential_envelope_gain.sv
// Top level of the exponential envelope gain: configuration registers, front,
// queue and back parts. Depends on eeg_pkg, eeg_front, eeg_queue and eeg_back.
//
// Channel   Handshake               Payload
// item      item_valid / item_stall action, sample_in
// result    result_valid / result_stall sample_out, active
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A start or end request goes from dispatch straight to the output state; a
// sample inside a block waits on the one-bit-per-cycle divider that finds the
// block position. A block's first sample can add two more divides, the shape
// normalisation and the table lookups. Reset clears the control state at once.
// A two-entry queue and the result register let either side stall on its own.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module exponential_envelope_gain (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_stall,
	input wire logic [1:0] action,
	input wire logic signed [15:0] sample_in,
	output logic result_valid,
	input wire logic result_stall,
	output logic signed [15:0] sample_out,
	output logic active,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data
);

	eeg_pkg::eeg_cfg_t cfg_q;
	eeg_pkg::eeg_item_t push_data;
	eeg_pkg::eeg_item_t q_data;
	eeg_pkg::eeg_stat_t stat;
	logic push;
	logic pop;
	logic q_full;
	logic q_not_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step <= 32'd0;
			cfg_q.duty_point <= 17'd3277;
			cfg_q.floor_gain <= 15'd0;
			cfg_q.rise_shape <= 16'd6554;
			cfg_q.fall_shape <= 16'd6554;
			cfg_q.fade_ratio <= 17'd3277;
			cfg_q.run_mode <= eeg_pkg::MODE_LOOP;
			cfg_q.block_length <= 9'd64;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				eeg_pkg::REG_PHASE_STEP: cfg_q.phase_step <= cfg_data;
				eeg_pkg::REG_DUTY_POINT: cfg_q.duty_point <= cfg_data[16:0];
				eeg_pkg::REG_FLOOR_GAIN: cfg_q.floor_gain <= cfg_data[14:0];
				eeg_pkg::REG_RISE_SHAPE: cfg_q.rise_shape <= cfg_data[15:0];
				eeg_pkg::REG_FALL_SHAPE: cfg_q.fall_shape <= cfg_data[15:0];
				eeg_pkg::REG_FADE_RATIO: cfg_q.fade_ratio <= cfg_data[16:0];
				eeg_pkg::REG_RUN_MODE: cfg_q.run_mode <= cfg_data[1:0];
				eeg_pkg::REG_BLOCK_LENGTH: cfg_q.block_length <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	eeg_front u_front (
		.item_valid(item_valid),
		.item_stall(item_stall),
		.action(action),
		.sample_in(sample_in),
		.queue_full(q_full),
		.push(push),
		.push_data(push_data)
	);

	eeg_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(q_full),
		.pop(pop),
		.pop_data(q_data),
		.not_empty(q_not_empty)
	);

	eeg_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_not_empty(q_not_empty),
		.q_data(q_data),
		.pop(pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.sample_out(sample_out),
		.active(active),
		.stat(stat)
	);

	`EEG_NEVER(a_push_full, clk, arst_n, push && q_full, "request pushed into a full queue")
	`EEG_ASSERT(a_pop_nonempty, clk, arst_n, pop |-> q_not_empty, "pop from an empty queue")
	`EEG_ASSERT(a_result_src, clk, arst_n, $rose(result_valid) |-> $past(!stat.idle), "result without work")
	`EEG_ASSERT(a_out_wait, clk, arst_n, stat.out_wait |-> (result_valid && result_stall), "back waits on a free result register")

endmodule

`default_nettype wire
